// ===== src/drrip_dead_block_replacement_assert.svh =====
// assertion helpers for the replacement engine
`ifndef DRRIP_DEAD_BLOCK_REPLACEMENT_ASSERT_SVH
`define DRRIP_DEAD_BLOCK_REPLACEMENT_ASSERT_SVH

// condition must hold in the same cycle
`define DRRIP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("replacement engine check failed");

// condition must hold in the following cycle
`define DRRIP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("replacement engine check failed");

`endif

// ===== src/drrip_pkg.sv =====
package drrip_pkg;

	localparam int NUM_SETS_DEF      = 2048;
	localparam int NUM_WAYS_DEF      = 16;
	localparam int LEADER_COUNT_DEF  = 64;
	localparam int SELECTOR_BITS_DEF = 10;

	// width of the valid mask field
	localparam int MASK_BITS = 16;

	localparam logic [1:0] RRPV_NEAR = 2'd0;
	localparam logic [1:0] RRPV_LONG = 2'd2;
	localparam logic [1:0] RRPV_DIST = 2'd3;
	localparam logic [1:0] DEAD_ZERO = 2'd0;
	localparam logic [1:0] DEAD_MAX  = 2'd3;

	typedef enum logic [1:0] {
		CAUSE_INVALID = 2'd0,
		CAUSE_DEAD    = 2'd1,
		CAUSE_RRIP    = 2'd2,
		CAUSE_UPDATE  = 2'd3
	} cause_t;

	typedef enum logic {
		MODE_VICTIM = 1'b0,
		MODE_UPDATE = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	typedef struct packed {
		logic [3:0] victim_way;
		cause_t     cause;
		logic       wr_rrpv;
		logic       wr_dead;
	} policy_res_t;

endpackage

// ===== src/drrip_dead_block_replacement.sv =====
// replacement engine: one transaction in, one result out per transaction
// result: row read at the accepting edge, then modified, written back and registered once the output has room
// one transaction at a time: no new one is accepted until the read-modify-write of its set row is done
// reset: async, active low; then a clearing pass over all NUM_SETS set rows (2048 by default)
// reset: in_stall stays high during the clearing pass; selector starts at its midpoint
module drrip_dead_block_replacement #(
	parameter int NUM_SETS      = drrip_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS      = drrip_pkg::NUM_WAYS_DEF,
	parameter int LEADER_COUNT  = drrip_pkg::LEADER_COUNT_DEF,
	parameter int SELECTOR_BITS = drrip_pkg::SELECTOR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [10:0] set_index,
	input  logic [3:0]  way_index,
	input  logic        was_hit,
	input  logic [15:0] valid_mask,
	input  logic [4:0]  random_draw,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  victim_way,
	output logic [1:0]  victim_cause,
	output logic [9:0]  selector_value
);
	import drrip_pkg::*;

	// NUM_SETS is a power of two, the set index wraps on its low bits
	localparam int SET_W = $clog2(NUM_SETS);
	localparam int ROW_W = 2 * NUM_WAYS;
	localparam logic [SELECTOR_BITS-1:0] SEL_MID = {1'b1, {(SELECTOR_BITS-1){1'b0}}};
	localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

	state_t state_q;
	logic [SET_W-1:0] clr_addr_q;

	logic accept, done;
	logic [SET_W+10:0] set_ext;
	logic [SET_W-1:0] set_addr;

	// item held while its row is read and rewritten
	logic             busy_s1;
	logic             mode_s1;
	logic [SET_W-1:0] set_s1;
	logic [3:0]       way_s1;
	logic             hit_s1;
	logic [15:0]      valid_s1;
	logic [4:0]       draw_s1;

	logic [SELECTOR_BITS-1:0] sel_q, sel_new;
	logic [SELECTOR_BITS+9:0] sel_ext;

	logic [ROW_W-1:0] rrpv_rd, dead_rd, rrpv_new, dead_new;
	logic [ROW_W-1:0] rrpv_wdata, dead_wdata;
	logic             rrpv_we, dead_we;
	logic [SET_W-1:0] waddr;
	policy_res_t      res;

	logic        out_valid_q;
	logic [3:0]  victim_way_q;
	cause_t      victim_cause_q;

	// one transaction at a time, none while the stores are being cleared
	assign in_stall = (state_q != ST_RUN) || busy_s1;
	assign accept   = in_valid && !in_stall;
	// finishing needs room in the output register
	assign done     = busy_s1 && (!out_valid_q || !out_stall);

	assign set_ext  = {{SET_W{1'b0}}, set_index};
	assign set_addr = set_ext[SET_W-1:0];

	// write port: clearing pass first, then write-back of the modified row
	always_comb begin
		if (state_q == ST_CLEAR) begin
			rrpv_we    = 1'b1;
			dead_we    = 1'b1;
			waddr      = clr_addr_q;
			rrpv_wdata = '1;
			dead_wdata = '0;
		end else begin
			rrpv_we    = done && res.wr_rrpv;
			dead_we    = done && res.wr_dead;
			waddr      = set_s1;
			rrpv_wdata = rrpv_new;
			dead_wdata = dead_new;
		end
	end

	// read data stays put while busy since no new read is issued
	drrip_meta_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_rrpv_ram (
		.clk   (clk),
		.we    (rrpv_we),
		.waddr (waddr),
		.wdata (rrpv_wdata),
		.re    (accept),
		.raddr (set_addr),
		.rdata (rrpv_rd)
	);

	drrip_meta_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_dead_ram (
		.clk   (clk),
		.we    (dead_we),
		.waddr (waddr),
		.wdata (dead_wdata),
		.re    (accept),
		.raddr (set_addr),
		.rdata (dead_rd)
	);

	drrip_policy #(
		.NUM_SETS      (NUM_SETS),
		.NUM_WAYS      (NUM_WAYS),
		.LEADER_COUNT  (LEADER_COUNT),
		.SELECTOR_BITS (SELECTOR_BITS)
	) u_policy (
		.mode        (mode_s1),
		.set_addr    (set_s1),
		.way_index   (way_s1),
		.was_hit     (hit_s1),
		.valid_mask  (valid_s1),
		.random_draw (draw_s1),
		.rrpv_row    (rrpv_rd),
		.dead_row    (dead_rd),
		.sel         (sel_q),
		.rrpv_new    (rrpv_new),
		.dead_new    (dead_new),
		.sel_new     (sel_new),
		.res         (res)
	);

	// control: clearing pass, stage occupancy, selector, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			busy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			sel_q       <= SEL_MID;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_SET) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
				sel_q       <= sel_new;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: transaction fields and result
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode;
			set_s1   <= set_addr;
			way_s1   <= way_index;
			hit_s1   <= was_hit;
			valid_s1 <= valid_mask;
			draw_s1  <= random_draw;
		end
		if (done) begin
			victim_way_q   <= res.victim_way;
			victim_cause_q <= res.cause;
		end
	end

	// selector after the transaction, taken straight from the register
	assign sel_ext        = {10'd0, sel_q};
	assign selector_value = sel_ext[9:0];
	assign out_valid      = out_valid_q;
	assign victim_way     = victim_way_q;
	assign victim_cause   = victim_cause_q;

`include "drrip_dead_block_replacement_assert.svh"

	`DRRIP_ASSERT_NOW(a_no_accept_clear, state_q == ST_CLEAR, !accept)
	`DRRIP_ASSERT_NEXT(a_accept_fills_stage, accept, busy_s1 && in_stall)
	`DRRIP_ASSERT_NEXT(a_done_shows_result, done, out_valid && !busy_s1)
	`DRRIP_ASSERT_NEXT(a_sel_hold, !done, $stable(sel_q))

endmodule

// ===== src/drrip_meta_ram.sv =====
module drrip_meta_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/drrip_policy.sv =====
module drrip_policy #(
	parameter int NUM_SETS      = drrip_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS      = drrip_pkg::NUM_WAYS_DEF,
	parameter int LEADER_COUNT  = drrip_pkg::LEADER_COUNT_DEF,
	parameter int SELECTOR_BITS = drrip_pkg::SELECTOR_BITS_DEF
) (
	input  logic                        mode,
	input  logic [$clog2(NUM_SETS)-1:0] set_addr,
	input  logic [3:0]                  way_index,
	input  logic                        was_hit,
	input  logic [15:0]                 valid_mask,
	input  logic [4:0]                  random_draw,
	input  logic [2*NUM_WAYS-1:0]       rrpv_row,
	input  logic [2*NUM_WAYS-1:0]       dead_row,
	input  logic [SELECTOR_BITS-1:0]    sel,
	output logic [2*NUM_WAYS-1:0]       rrpv_new,
	output logic [2*NUM_WAYS-1:0]       dead_new,
	output logic [SELECTOR_BITS-1:0]    sel_new,
	output drrip_pkg::policy_res_t      res
);
	import drrip_pkg::*;

	localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
	localparam logic [SELECTOR_BITS-1:0] SEL_MID = {1'b1, {(SELECTOR_BITS-1){1'b0}}};

	// ways above the mask width count as valid
	logic [NUM_WAYS+MASK_BITS-1:0] valid_ext;

	logic       inv_found, dead_found;
	logic [3:0] inv_way, dead_way, rrip_way;
	logic       have3, have2, have1;
	logic [1:0] rrpv_max, age_step;
	logic [1:0] dead_old, dead_inc, fill_rrpv;
	logic       way_ok, is_brrip, is_srrip, srrip_ins;

	assign valid_ext = {{NUM_WAYS{1'b1}}, valid_mask};

	// victim search, lowest way wins in each class
	always_comb begin
		inv_found  = 1'b0;
		dead_found = 1'b0;
		inv_way    = '0;
		dead_way   = '0;
		have3      = 1'b0;
		have2      = 1'b0;
		have1      = 1'b0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (!valid_ext[w]) begin
				inv_found = 1'b1;
				inv_way   = 4'(w);
			end
			if (dead_row[2*w +: 2] == DEAD_MAX) begin
				dead_found = 1'b1;
				dead_way   = 4'(w);
			end
			have3 = have3 | (rrpv_row[2*w +: 2] == 2'd3);
			have2 = have2 | (rrpv_row[2*w +: 2] == 2'd2);
			have1 = have1 | (rrpv_row[2*w +: 2] == 2'd1);
		end
		priority if (have3) rrpv_max = 2'd3;
		else if (have2)     rrpv_max = 2'd2;
		else if (have1)     rrpv_max = 2'd1;
		else                rrpv_max = 2'd0;
		age_step = RRPV_DIST - rrpv_max;
		rrip_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (rrpv_row[2*w +: 2] == rrpv_max) begin
				rrip_way = 4'(w);
			end
		end
	end

	// leader classification and insertion position
	always_comb begin
		is_brrip  = (32'(set_addr) + 32'(LEADER_COUNT)) >= 32'(NUM_SETS);
		is_srrip  = !is_brrip && (32'(set_addr) < 32'(LEADER_COUNT));
		srrip_ins = is_srrip || (!is_brrip && (sel >= SEL_MID));
		way_ok    = 32'(way_index) < 32'(NUM_WAYS);
		dead_old  = DEAD_ZERO;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (32'(way_index) == w) begin
				dead_old = dead_row[2*w +: 2];
			end
		end
		dead_inc = (dead_old == DEAD_MAX) ? DEAD_MAX : dead_old + 2'd1;
		if (dead_inc == DEAD_MAX) begin
			fill_rrpv = RRPV_DIST;
		end else if (srrip_ins || random_draw == 5'd0) begin
			fill_rrpv = RRPV_LONG;
		end else begin
			fill_rrpv = RRPV_DIST;
		end
	end

	always_comb begin
		rrpv_new = rrpv_row;
		dead_new = dead_row;
		sel_new  = sel;
		res      = '{victim_way: 4'd0, cause: CAUSE_UPDATE, wr_rrpv: 1'b0, wr_dead: 1'b0};
		if (mode == MODE_VICTIM) begin
			priority if (inv_found) begin
				res.victim_way = inv_way;
				res.cause      = CAUSE_INVALID;
			end else if (dead_found) begin
				res.victim_way = dead_way;
				res.cause      = CAUSE_DEAD;
			end else begin
				res.victim_way = rrip_way;
				res.cause      = CAUSE_RRIP;
				res.wr_rrpv    = 1'b1;
				for (int w = 0; w < NUM_WAYS; w++) begin
					rrpv_new[2*w +: 2] = rrpv_row[2*w +: 2] + age_step;
				end
			end
		end else if (way_ok) begin
			res.wr_rrpv = 1'b1;
			res.wr_dead = 1'b1;
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (32'(way_index) == w) begin
					dead_new[2*w +: 2] = was_hit ? DEAD_ZERO : dead_inc;
					rrpv_new[2*w +: 2] = was_hit ? RRPV_NEAR : fill_rrpv;
				end
			end
			if (was_hit) begin
				if (is_srrip && sel != SEL_MAX) begin
					sel_new = sel + 1'b1;
				end else if (is_brrip && sel != '0) begin
					sel_new = sel - 1'b1;
				end
			end
		end
	end

endmodule
